// ----- design/anc_pkg.sv -----
`timescale 1ns / 1ps

package anc_pkg;

   // Width of the divisor sum on the result port.
   localparam int SUM_WIDTH = 36;

   // Search radius register.
   localparam int RADIUS_WIDTH = 8;
   localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = 8'd3;

   // Command codes.
   localparam logic CMD_PAIR   = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM_A,
      ST_CHECK,
      ST_SUM_B,
      ST_FINISH
   } anc_state_type;

   typedef enum logic [1:0] {
      SUM_IDLE,
      SUM_TEST,
      SUM_WAIT
   } anc_sum_state_type;

endpackage

// ----- design/anc_divider.sv -----
`timescale 1ns / 1ps

module anc_divider #(
   parameter int WIDTH = 21
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] div_ff, div_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   diff;

   // One restoring step per cycle: the dividend shifts out of the quotient
   // register into the partial remainder as the quotient bits shift in.
   always_comb begin
      shifted  = {rem_ff, quo_ff[WIDTH-1]};
      diff     = shifted - {1'b0, div_ff};
      run_in   = run_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         run_in   = 1'b1;
         count_in = CNT_W'(WIDTH);
         quo_in   = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (run_ff) begin
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = diff[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         run_ff   <= run_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- design/anc_divsum.sv -----
`timescale 1ns / 1ps

module anc_divsum #(
   parameter int OP_W  = 21,
   parameter int ACC_W = 25
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [OP_W-1:0]  value,
   output logic             done,
   output logic [ACC_W-1:0] result
);

   localparam int SQ_W = OP_W + 2;

   anc_pkg::anc_sum_state_type state_ff, state_in;

   logic [OP_W-1:0]  v_ff, v_in;
   logic [OP_W-1:0]  d_ff, d_in;
   logic [SQ_W-1:0]  sq_ff, sq_in;
   logic [ACC_W-1:0] total_ff, total_in;
   logic [ACC_W-1:0] result_ff, result_in;
   logic             done_ff, done_in;
   logic             div_start;
   logic             div_done;
   logic [OP_W-1:0]  quotient;
   logic [OP_W-1:0]  remainder;

   anc_divider #(
      .WIDTH(OP_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (v_ff),
      .divisor  (d_ff),
      .done     (div_done),
      .quotient (quotient),
      .remainder(remainder)
   );

   // Trial division up to the square root: each divisor d found also gives
   // its cofactor v/d. The square of d is kept by adding 2d+1 each step, and
   // v itself is taken off the total at the end.
   always_comb begin
      state_in  = state_ff;
      v_in      = v_ff;
      d_in      = d_ff;
      sq_in     = sq_ff;
      total_in  = total_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         anc_pkg::SUM_IDLE: begin
            if (start) begin
               v_in     = value;
               d_in     = OP_W'(1);
               sq_in    = SQ_W'(1);
               total_in = '0;
               if (value < OP_W'(2)) begin
                  result_in = ACC_W'(1);
                  done_in   = 1'b1;
               end else begin
                  state_in = anc_pkg::SUM_TEST;
               end
            end
         end
         anc_pkg::SUM_TEST: begin
            if (sq_ff > SQ_W'(v_ff)) begin
               result_in = total_ff - ACC_W'(v_ff);
               done_in   = 1'b1;
               state_in  = anc_pkg::SUM_IDLE;
            end else begin
               div_start = 1'b1;
               state_in  = anc_pkg::SUM_WAIT;
            end
         end
         anc_pkg::SUM_WAIT: begin
            if (div_done) begin
               if (remainder == '0) begin
                  total_in = total_ff + ACC_W'(d_ff)
                           + ((quotient != d_ff) ? ACC_W'(quotient) : '0);
               end
               sq_in    = sq_ff + SQ_W'({d_ff, 1'b1});
               d_in     = d_ff + OP_W'(1);
               state_in = anc_pkg::SUM_TEST;
            end
         end
         default: state_in = anc_pkg::SUM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= anc_pkg::SUM_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff      <= v_in;
      d_ff      <= d_in;
      sq_ff     <= sq_in;
      total_ff  <= total_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ----- design/amicable_number_checker_top.sv -----
`timescale 1ns / 1ps

// Channel   Ports                                  Handshake
// request   req_command, req_first_value,          start high while busy low
//           req_second_value
// response  rsp_is_amicable, rsp_first_divisor_sum rsp_strobe, one cycle each
// csr       csr_search_radius                      csr_valid and csr_ready
//
// A divisor sum of v takes about floor(sqrt(v)) trial divisions on the one
// shared restoring divider (OP_W is one bit wider than the wider of
// VALUE_WIDTH and the radius), each followed by a step of loop control; a
// transaction needs one or two such sums.
// The synchronous reset clears the control state and sets the search radius
// to three. The receiver cannot stall: each result shows for one cycle.
module amicable_number_checker_top #(
   parameter int VALUE_WIDTH = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_command,
   input  logic [VALUE_WIDTH-1:0]              req_first_value,
   input  logic [VALUE_WIDTH-1:0]              req_second_value,
   output logic                                rsp_strobe,
   output logic                                rsp_is_amicable,
   output logic [anc_pkg::SUM_WIDTH-1:0]       rsp_first_divisor_sum,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [anc_pkg::RADIUS_WIDTH-1:0]    csr_search_radius
);

   // In a search the second sum may be taken of a value up to first_value + radius.
   localparam int OP_W  = ((VALUE_WIDTH > anc_pkg::RADIUS_WIDTH) ?
                           VALUE_WIDTH : anc_pkg::RADIUS_WIDTH) + 1;
   localparam int ACC_W = OP_W + 4;

   anc_pkg::anc_state_type state_ff, state_in;

   logic                             cmd_ff, cmd_in;
   logic [VALUE_WIDTH-1:0]           a_ff, a_in;
   logic [VALUE_WIDTH-1:0]           b_ff, b_in;
   logic [ACC_W-1:0]                 sa_ff, sa_in;
   logic [anc_pkg::RADIUS_WIDTH-1:0] radius_ff, radius_in;
   logic                             strobe_ff, strobe_in;
   logic                             hit_ff, hit_in;
   logic [anc_pkg::SUM_WIDTH-1:0]    sum_out_ff, sum_out_in;
   logic                             sum_start;
   logic [OP_W-1:0]                  sum_value;
   logic                             sum_done;
   logic [ACC_W-1:0]                 sum_result;
   logic [ACC_W-1:0]                 a_ext;
   logic [ACC_W-1:0]                 r_ext;
   logic [ACC_W-1:0]                 lo;
   logic [ACC_W-1:0]                 hi;
   logic [63:0]                      sa_wide;

   anc_divsum #(
      .OP_W (OP_W),
      .ACC_W(ACC_W)
   ) u_divsum (
      .clock (clock),
      .reset (reset),
      .start (sum_start),
      .value (sum_value),
      .done  (sum_done),
      .result(sum_result)
   );

   assign a_ext   = ACC_W'(a_ff);
   assign r_ext   = ACC_W'(radius_ff);
   assign hi      = a_ext + r_ext;
   assign sa_wide = 64'(sa_ff);

   always_comb begin
      lo = (a_ext > r_ext) ? (a_ext - r_ext) : '0;
      if (lo < ACC_W'(1)) begin
         lo = ACC_W'(1);
      end
   end

   assign radius_in = (csr_valid && csr_ready) ? csr_search_radius : radius_ff;

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      sa_in      = sa_ff;
      hit_in     = hit_ff;
      strobe_in  = 1'b0;
      sum_out_in = sum_out_ff;
      sum_start  = 1'b0;
      sum_value  = OP_W'(req_first_value);
      unique case (state_ff)
         anc_pkg::ST_IDLE: begin
            if (start) begin
               cmd_in    = req_command;
               a_in      = req_first_value;
               b_in      = req_second_value;
               hit_in    = 1'b0;
               sum_start = 1'b1;
               state_in  = anc_pkg::ST_SUM_A;
            end
         end
         anc_pkg::ST_SUM_A: begin
            if (sum_done) begin
               sa_in    = sum_result;
               state_in = anc_pkg::ST_CHECK;
            end
         end
         anc_pkg::ST_CHECK: begin
            // Only c = s(a) can satisfy s(a) == c, so one more sum settles it.
            if (cmd_ff == anc_pkg::CMD_PAIR) begin
               sum_value = OP_W'(b_ff);
               if (sa_ff == ACC_W'(b_ff)) begin
                  sum_start = 1'b1;
                  state_in  = anc_pkg::ST_SUM_B;
               end else begin
                  state_in = anc_pkg::ST_FINISH;
               end
            end else begin
               sum_value = sa_ff[OP_W-1:0];
               if ((sa_ff >= lo) && (sa_ff <= hi)) begin
                  sum_start = 1'b1;
                  state_in  = anc_pkg::ST_SUM_B;
               end else begin
                  state_in = anc_pkg::ST_FINISH;
               end
            end
         end
         anc_pkg::ST_SUM_B: begin
            if (sum_done) begin
               hit_in   = (sum_result == a_ext);
               state_in = anc_pkg::ST_FINISH;
            end
         end
         anc_pkg::ST_FINISH: begin
            strobe_in  = 1'b1;
            sum_out_in = sa_wide[anc_pkg::SUM_WIDTH-1:0];
            state_in   = anc_pkg::ST_IDLE;
         end
         default: state_in = anc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= anc_pkg::ST_IDLE;
         strobe_ff <= 1'b0;
         radius_ff <= anc_pkg::RADIUS_RESET;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         radius_ff <= radius_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      sa_ff      <= sa_in;
      hit_ff     <= hit_in;
      sum_out_ff <= sum_out_in;
   end

   assign busy                  = (state_ff != anc_pkg::ST_IDLE);
   assign csr_ready             = !busy;
   assign rsp_strobe            = strobe_ff;
   assign rsp_is_amicable       = hit_ff;
   assign rsp_first_divisor_sum = sum_out_ff;

   // A transaction ends only by handing out its result.
   a_busy_ends_with_result: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_strobe)
      else $error("busy fell without a result strobe");

   // Each transaction gives a single result.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // A result follows a busy period.
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a transaction in progress");

endmodule

// ----- test/anc_result_checker.sv -----
`timescale 1ns / 1ps

module anc_result_checker #(
   parameter int VALUE_WIDTH = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic                             req_command,
   input  logic [VALUE_WIDTH-1:0]           req_first_value,
   input  logic [VALUE_WIDTH-1:0]           req_second_value,
   input  logic                             rsp_strobe,
   input  logic                             rsp_is_amicable,
   input  logic [anc_pkg::SUM_WIDTH-1:0]    rsp_first_divisor_sum,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [anc_pkg::RADIUS_WIDTH-1:0] csr_search_radius,
   output int unsigned                      fail_count,
   output int unsigned                      pending_count
);

   typedef struct packed {
      logic                          is_amicable;
      logic [anc_pkg::SUM_WIDTH-1:0] divisor_sum;
   } verdict_type;

   verdict_type                      awaited_verdicts[$];
   logic [anc_pkg::RADIUS_WIDTH-1:0] radius;

   // One plus every proper divisor from 2 up to v/2; 0 and 1 both give 1.
   function automatic longint unsigned aliquot_sum(input longint unsigned v);
      longint unsigned d;
      longint unsigned total;
      if (v < 2) return 1;
      total = 0;
      for (d = 1; d * d <= v; d++) begin
         if (v % d == 0) begin
            total += d;
            if (v / d != d) total += v / d;
         end
      end
      return total - v;
   endfunction

   function automatic verdict_type predict_verdict(
      input logic                             cmd,
      input logic [VALUE_WIDTH-1:0]           a_in,
      input logic [VALUE_WIDTH-1:0]           b_in,
      input logic [anc_pkg::RADIUS_WIDTH-1:0] r);
      longint unsigned a;
      longint unsigned b;
      longint unsigned sa;
      longint unsigned lo;
      longint unsigned hi;
      verdict_type     v;
      a = a_in;
      b = b_in;
      sa = aliquot_sum(a);
      v.is_amicable = 1'b0;
      if (cmd == anc_pkg::CMD_PAIR) begin
         v.is_amicable = (sa == b) && (aliquot_sum(b) == a);
      end else begin
         // Only c = s(a) can satisfy s(a) == c, so the search reduces to one candidate.
         lo = (a > r) ? a - r : 0;
         hi = a + r;
         if (lo < 1) lo = 1;
         if (sa >= lo && sa <= hi) v.is_amicable = (aliquot_sum(sa) == a);
      end
      v.divisor_sum = sa[anc_pkg::SUM_WIDTH-1:0];
      return v;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      fail_count++;
   endtask

   always @(posedge clock) begin : watch_channels
      verdict_type want;
      if (reset) begin
         radius <= anc_pkg::RADIUS_RESET;
         awaited_verdicts.delete();
         fail_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (awaited_verdicts.size() == 0) begin
               report_mismatch("result with no transaction outstanding");
            end else begin
               want = awaited_verdicts.pop_front();
               if (rsp_is_amicable !== want.is_amicable)
                  report_mismatch($sformatf("is_amicable got %b, want %b",
                                            rsp_is_amicable, want.is_amicable));
               if (rsp_first_divisor_sum !== want.divisor_sum)
                  report_mismatch($sformatf("first_divisor_sum got %0d, want %0d",
                                            rsp_first_divisor_sum, want.divisor_sum));
            end
         end
         if (start && !busy)
            awaited_verdicts.push_back(predict_verdict(req_command, req_first_value,
                                                       req_second_value, radius));
         if (csr_valid && csr_ready) radius <= csr_search_radius;
      end
      pending_count = awaited_verdicts.size();
   end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   localparam int          VALUE_WIDTH   = 20;
   localparam int unsigned CYCLE_LIMIT   = 20_000_000;
   localparam int          SETTLE_CYCLES = 64;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   logic                             req_command = anc_pkg::CMD_PAIR;
   logic [VALUE_WIDTH-1:0]           req_first_value = '0;
   logic [VALUE_WIDTH-1:0]           req_second_value = '0;
   logic                             rsp_strobe;
   logic                             rsp_is_amicable;
   logic [anc_pkg::SUM_WIDTH-1:0]    rsp_first_divisor_sum;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [anc_pkg::RADIUS_WIDTH-1:0] csr_search_radius = '0;

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned cycle_count = 0;
   int          burst_left = 0;

   // Members of amicable pairs; the partner of entry i sits at entry i ^ 1.
   // The last four are larger and cost more cycles, so they are drawn rarely.
   int unsigned amicable_members [20] = '{220, 284, 1184, 1210, 2620, 2924, 5020, 5564,
                                          6232, 6368, 10744, 10856, 12285, 14595,
                                          17296, 18416, 63020, 76084, 66928, 66992};
   int unsigned perfect_numbers [4] = '{6, 28, 496, 8128};

   always #5 clock = ~clock;

   amicable_number_checker_top #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) uut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_command           (req_command),
      .req_first_value       (req_first_value),
      .req_second_value      (req_second_value),
      .rsp_strobe            (rsp_strobe),
      .rsp_is_amicable       (rsp_is_amicable),
      .rsp_first_divisor_sum (rsp_first_divisor_sum),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_search_radius     (csr_search_radius)
   );

   anc_result_checker #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) checker_inst (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_command           (req_command),
      .req_first_value       (req_first_value),
      .req_second_value      (req_second_value),
      .rsp_strobe            (rsp_strobe),
      .rsp_is_amicable       (rsp_is_amicable),
      .rsp_first_divisor_sum (rsp_first_divisor_sum),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_search_radius     (csr_search_radius),
      .fail_count            (fail_count),
      .pending_count         (pending_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Start stays high into the next transaction while a burst lasts, so the
   // following call simply replaces the request fields.
   task automatic send_item(input logic cmd, input int unsigned a, input int unsigned b);
      int gap;
      start = 1'b1;
      req_command = cmd;
      req_first_value = a[VALUE_WIDTH-1:0];
      req_second_value = b[VALUE_WIDTH-1:0];
      do @(posedge clock); while (busy);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start = 1'b0;
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 4000) : $urandom_range(1, 12);
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(0, 6);
      end
   endtask

   task automatic settle();
      start = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_radius(input int unsigned r);
      csr_valid = 1'b1;
      csr_search_radius = r[anc_pkg::RADIUS_WIDTH-1:0];
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin : stimulus
      int   phase;
      int   i;
      int   kind;
      int   pick;
      int   a;
      int   b;
      logic cmd;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, first with the radius left at its reset value.
      send_item(anc_pkg::CMD_PAIR, 220, 284);
      send_item(anc_pkg::CMD_PAIR, 284, 220);
      send_item(anc_pkg::CMD_PAIR, 1, 1);
      send_item(anc_pkg::CMD_PAIR, 6, 6);
      send_item(anc_pkg::CMD_PAIR, 220, 285);
      send_item(anc_pkg::CMD_PAIR, 12, 16);
      send_item(anc_pkg::CMD_PAIR, 1048575, 1048575);
      send_item(anc_pkg::CMD_PAIR, 898216, 980984);
      send_item(anc_pkg::CMD_PAIR, 2, 1);
      send_item(anc_pkg::CMD_SEARCH, 28, 1);
      send_item(anc_pkg::CMD_SEARCH, 1, 1);
      send_item(anc_pkg::CMD_SEARCH, 2, 3);
      send_item(anc_pkg::CMD_SEARCH, 220, 284);
      send_item(anc_pkg::CMD_SEARCH, 1048575, 524288);
      settle();
      write_radius(0);
      send_item(anc_pkg::CMD_SEARCH, 496, 1);
      send_item(anc_pkg::CMD_SEARCH, 1, 1);
      send_item(anc_pkg::CMD_SEARCH, 220, 1);
      settle();
      // The partners 220 and 284 lie exactly 64 apart.
      write_radius(64);
      send_item(anc_pkg::CMD_SEARCH, 220, 1);
      send_item(anc_pkg::CMD_SEARCH, 284, 1);
      settle();
      write_radius(63);
      send_item(anc_pkg::CMD_SEARCH, 220, 1);
      settle();
      write_radius(255);
      send_item(anc_pkg::CMD_SEARCH, 1184, 1);
      send_item(anc_pkg::CMD_SEARCH, 12, 1);
      send_item(anc_pkg::CMD_SEARCH, 1048575, 1);
      send_item(anc_pkg::CMD_PAIR, 17296, 18416);
      settle();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_radius(0);
            1: write_radius(255);
            2: write_radius($urandom_range(1, 254));
            default: write_radius($urandom_range(0, 255));
         endcase
         for (i = 0; i < 25; i++) begin
            kind = $urandom_range(0, 99);
            pick = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 19) : $urandom_range(0, 15);
            if (kind < 30) begin
               a = amicable_members[pick];
               b = amicable_members[pick ^ 1];
               if ($urandom_range(0, 3) == 0) b = b + $urandom_range(0, 2) - 1;
               send_item(anc_pkg::CMD_PAIR, a, b);
            end else if (kind < 40) begin
               a = perfect_numbers[$urandom_range(0, 3)];
               b = ($urandom_range(0, 3) == 0) ? a + 1 : a;
               send_item(anc_pkg::CMD_PAIR, a, b);
            end else if (kind < 75) begin
               a = ($urandom_range(0, 4) == 0) ? perfect_numbers[$urandom_range(0, 3)]
                                                : amicable_members[pick];
               if ($urandom_range(0, 4) < 2) a = a + $urandom_range(0, 6) - 3;
               if (a < 1) a = 1;
               send_item(anc_pkg::CMD_SEARCH, a, $urandom_range(1, 4095));
            end else if (kind < 95) begin
               cmd = ($urandom_range(0, 1) == 0) ? anc_pkg::CMD_PAIR : anc_pkg::CMD_SEARCH;
               send_item(cmd, $urandom_range(1, 4095), $urandom_range(1, 4095));
            end else begin
               cmd = ($urandom_range(0, 1) == 0) ? anc_pkg::CMD_PAIR : anc_pkg::CMD_SEARCH;
               send_item(cmd, $urandom_range(1, 1048575), $urandom_range(1, 1048575));
            end
         end
         settle();
      end

      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/anc_pkg.sv
design/anc_divider.sv
design/anc_divsum.sv
design/amicable_number_checker_top.sv
test/anc_result_checker.sv
test/tb_top.sv
